// ----- rtl/core/klein_edge_length_assert.svh -----
// Assertion macros for the edge length block.
`ifndef KLEIN_EDGE_LENGTH_ASSERT_SVH
`define KLEIN_EDGE_LENGTH_ASSERT_SVH

// Check cons in the same cycle as ante.
`define KEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons one pipeline latency after ante.
`define KEL_ASSERT_LAT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##KEL_LATENCY (cons)) else $error(msg);

`endif

// ----- rtl/core/kel_pkg.sv -----
package kel_pkg;

  localparam int COORD_FRAC_BITS = 30;
  localparam int KEL_PROD_FRAC   = 2 * COORD_FRAC_BITS - 2;
  localparam logic signed [63:0] KEL_ONE = $signed(64'd1 << KEL_PROD_FRAC);

  localparam int KEL_MAG_W  = 63;
  localparam int KEL_PROD_W = 126;
  localparam int KEL_RAD_W  = 124;
  localparam int KEL_ROOT_W = 62;
  localparam int KEL_REM_W  = 64;

  localparam int KEL_LOG_K_W    = 6;
  localparam int KEL_LOG_FRAC_W = 32;
  localparam int KEL_LOG_W      = KEL_LOG_K_W + KEL_LOG_FRAC_W;
  localparam int KEL_MANT_W     = 31;

  localparam logic [31:0] KEL_LN2_Q32 = 32'd2977044472;

  localparam int KEL_FRONT_STAGES = 7;
  localparam int KEL_ROOT_STAGES  = KEL_ROOT_W;
  localparam int KEL_LOG_NORM     = 3;
  localparam int KEL_LOG_ITERS    = KEL_LOG_FRAC_W;
  localparam int KEL_LOG_STAGES   = KEL_LOG_NORM + KEL_LOG_ITERS;
  localparam int KEL_BACK_STAGES  = 3;
  localparam int KEL_LATENCY      = KEL_FRONT_STAGES + KEL_ROOT_STAGES + KEL_LOG_STAGES +
                                    KEL_BACK_STAGES;

  typedef struct packed {
    logic [KEL_RAD_W-1:0]  rad;
    logic [KEL_REM_W-1:0]  rem;
    logic [KEL_ROOT_W-1:0] root;
  } kel_root_t;

  typedef struct packed {
    logic                 ok;
    logic [KEL_MAG_W-1:0] un;
    logic [KEL_MAG_W-1:0] ua;
    logic [KEL_MAG_W-1:0] ub;
  } kel_side_t;

endpackage

// ----- rtl/core/klein_edge_length.sv -----
// Channel   Direction  Handshake              Payload
// input     in         start (busy is low)    in_head_x/y/z, in_tail_x/y/z
// result    out        out_strobe, one cycle  out_edge_length, out_outside_disk
// config    in         cfg_we                 cfg_wdata (space_dims)
//
// One transaction per cycle; busy stays low, so start may be held every cycle.
// The pipeline has 7 front stages for the dot products and
// wide squares, 62 square root stages (one root bit each), 35 log2 stages
// (normalize, then one squaring per fraction bit) and 3 output stages.
// Reset clears the valid bits and loads space_dims with 3.
// The receiver cannot stall; each result shows for exactly one cycle.
module klein_edge_length import kel_pkg::*; #(
  parameter int MAX_DIMS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_head_x,
  input  logic [31:0] in_head_y,
  input  logic [31:0] in_head_z,
  input  logic [31:0] in_tail_x,
  input  logic [31:0] in_tail_y,
  input  logic [31:0] in_tail_z,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  output logic        out_strobe,
  output logic [31:0] out_edge_length,
  output logic        out_outside_disk
);

  logic [1:0] space_dims_r;
  logic [1:0] dims_eff;
  logic [MAX_DIMS-1:0] lane_en;

  logic signed [31:0] head_all [3];
  logic signed [31:0] tail_all [3];
  logic signed [31:0] head_v [MAX_DIMS];
  logic signed [31:0] tail_v [MAX_DIMS];

  logic      vld_q  [KEL_ROOT_STAGES+1];
  kel_root_t root_q [KEL_ROOT_STAGES+1];
  kel_side_t side_q [KEL_ROOT_STAGES+1];

  logic [63:0]          log_x [3];
  logic [2:0]           log_v;
  logic [KEL_LOG_W-1:0] log_res [3];
  logic [KEL_LOG_STAGES-1:0] ok_dly_r;

  logic signed [40:0] d_nxt;
  logic        d1_v_r, d1_ok_r, d1_pos_r;
  logic [30:0] d1_q_r;
  logic        d2_v_r, d2_ok_r, d2_pos_r;
  logic [62:0] d2_prod_r;
  logic [63:0] rnd;
  logic        strobe_r, outside_r;
  logic [31:0] len_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_dims_r <= 2'd3;
    end else if (cfg_we) begin
      space_dims_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (space_dims_r < 2'd2) begin
      dims_eff = 2'd2;
    end else if (space_dims_r > 2'(MAX_DIMS)) begin
      dims_eff = 2'(MAX_DIMS);
    end else begin
      dims_eff = space_dims_r;
    end
    head_all[0] = in_head_x;
    head_all[1] = in_head_y;
    head_all[2] = in_head_z;
    tail_all[0] = in_tail_x;
    tail_all[1] = in_tail_y;
    tail_all[2] = in_tail_z;
    for (int i = 0; i < MAX_DIMS; i++) begin
      lane_en[i] = 2'(i) < dims_eff;
      head_v[i]  = head_all[i];
      tail_v[i]  = tail_all[i];
    end
  end

  kel_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .lane_en   (lane_en),
    .head      (head_v),
    .tail      (tail_v),
    .out_valid (vld_q[0]),
    .out_root  (root_q[0]),
    .out_side  (side_q[0])
  );

  for (genvar j = 0; j < KEL_ROOT_STAGES; j++) begin : g_root
    kel_root_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_q[j]),
      .in_root   (root_q[j]),
      .in_side   (side_q[j]),
      .out_valid (vld_q[j+1]),
      .out_root  (root_q[j+1]),
      .out_side  (side_q[j+1])
    );
  end

  assign log_x[0] = 64'(side_q[KEL_ROOT_STAGES].un) + 64'(root_q[KEL_ROOT_STAGES].root);
  assign log_x[1] = 64'(side_q[KEL_ROOT_STAGES].ua);
  assign log_x[2] = 64'(side_q[KEL_ROOT_STAGES].ub);

  for (genvar l = 0; l < 3; l++) begin : g_log
    kel_log2 u_log (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_q[KEL_ROOT_STAGES]),
      .in_x      (log_x[l]),
      .out_valid (log_v[l]),
      .out_log   (log_res[l])
    );
  end

  always_ff @(posedge clk) begin
    ok_dly_r <= {ok_dly_r[KEL_LOG_STAGES-2:0], side_q[KEL_ROOT_STAGES].ok};
  end

  always_comb begin
    d_nxt = $signed({2'b00, log_res[0], 1'b0}) - $signed({3'b000, log_res[1]})
          - $signed({3'b000, log_res[2]});
    rnd   = {1'b0, d2_prod_r} + (64'd1 << 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r   <= 1'b0;
      d2_v_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      d1_v_r   <= &log_v;
      d2_v_r   <= d1_v_r;
      strobe_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_ok_r   <= ok_dly_r[KEL_LOG_STAGES-1];
    d1_pos_r  <= ok_dly_r[KEL_LOG_STAGES-1] && !d_nxt[40] && (d_nxt != '0);
    d1_q_r    <= d_nxt[38:8];
    d2_ok_r   <= d1_ok_r;
    d2_pos_r  <= d1_pos_r;
    d2_prod_r <= 63'(d1_q_r) * 63'(KEL_LN2_Q32);
    outside_r <= !d2_ok_r;
    len_r     <= d2_pos_r ? 32'(rnd[63:33]) : 32'd0;
  end

  assign out_strobe       = strobe_r;
  assign out_edge_length  = len_r;
  assign out_outside_disk = outside_r;

endmodule

// ----- rtl/core/kel_front.sv -----
module kel_front import kel_pkg::*; #(
  parameter int MAX_DIMS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [MAX_DIMS-1:0] lane_en,
  input  logic signed [31:0] head [MAX_DIMS],
  input  logic signed [31:0] tail [MAX_DIMS],
  output logic               out_valid,
  output kel_root_t          out_root,
  output kel_side_t          out_side
);

  logic [KEL_FRONT_STAGES-1:0] v_r;

  logic signed [31:0] h_r [MAX_DIMS];
  logic signed [31:0] t_r [MAX_DIMS];
  logic signed [61:0] ht_r [MAX_DIMS];
  logic signed [61:0] hh_r [MAX_DIMS];
  logic signed [61:0] tt_r [MAX_DIMS];
  logic signed [63:0] n_r, a_r, b_r;
  kel_side_t          side3_r, side4_r, side5_r, side6_r;
  logic [63:0]        nn_ll_r, nn_lh_r, ab_ll_r, ab_lh_r, ab_hl_r;
  logic [61:0]        nn_hh_r, ab_hh_r;
  logic [KEL_PROD_W-1:0] nn_r, ab_r;
  logic [KEL_RAD_W-1:0]  rad_r;

  logic signed [63:0] ht_full [MAX_DIMS];
  logic signed [63:0] hh_full [MAX_DIMS];
  logic signed [63:0] tt_full [MAX_DIMS];
  logic signed [63:0] n_nxt, a_nxt, b_nxt;
  logic               a_pos, a_neg, b_pos, b_neg, n_pos;
  logic [63:0]        ua_full, ub_full;
  kel_side_t          side3_nxt;
  kel_side_t          side6_nxt;
  logic [64:0]        nn_mid, ab_mid;
  logic [KEL_PROD_W-1:0] nn_nxt, ab_nxt;
  logic [KEL_PROD_W:0]   diff;

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      ht_full[i] = h_r[i] * t_r[i];
      hh_full[i] = h_r[i] * h_r[i];
      tt_full[i] = t_r[i] * t_r[i];
    end
  end

  always_comb begin
    n_nxt = KEL_ONE;
    a_nxt = KEL_ONE;
    b_nxt = KEL_ONE;
    for (int i = 0; i < MAX_DIMS; i++) begin
      n_nxt = n_nxt - 64'(ht_r[i]);
      a_nxt = a_nxt - 64'(hh_r[i]);
      b_nxt = b_nxt - 64'(tt_r[i]);
    end
  end

  always_comb begin
    a_neg   = a_r[63];
    b_neg   = b_r[63];
    a_pos   = !a_r[63] && (a_r != '0);
    b_pos   = !b_r[63] && (b_r != '0);
    n_pos   = !n_r[63] && (n_r != '0);
    ua_full = a_neg ? 64'(-a_r) : 64'(a_r);
    ub_full = b_neg ? 64'(-b_r) : 64'(b_r);
    side3_nxt.ok = ((a_pos && b_pos) || (a_neg && b_neg)) && n_pos;
    side3_nxt.un = n_r[KEL_MAG_W-1:0];
    side3_nxt.ua = ua_full[KEL_MAG_W-1:0];
    side3_nxt.ub = ub_full[KEL_MAG_W-1:0];
  end

  always_comb begin
    nn_mid = {nn_lh_r, 1'b0};
    ab_mid = 65'(ab_lh_r) + 65'(ab_hl_r);
    nn_nxt = {nn_hh_r, nn_ll_r} + KEL_PROD_W'({nn_mid, 32'd0});
    ab_nxt = {ab_hh_r, ab_ll_r} + KEL_PROD_W'({ab_mid, 32'd0});
    diff   = {1'b0, nn_r} - {1'b0, ab_r};
    side6_nxt    = side5_r;
    side6_nxt.ok = side5_r.ok && !diff[KEL_PROD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[KEL_FRONT_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      h_r[i]  <= lane_en[i] ? head[i] : 32'sd0;
      t_r[i]  <= lane_en[i] ? tail[i] : 32'sd0;
      ht_r[i] <= ht_full[i][63:2];
      hh_r[i] <= hh_full[i][63:2];
      tt_r[i] <= tt_full[i][63:2];
    end
    n_r     <= n_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    side3_r <= side3_nxt;

    nn_ll_r <= 64'(side3_r.un[31:0]) * 64'(side3_r.un[31:0]);
    nn_lh_r <= 64'(side3_r.un[31:0]) * 64'(side3_r.un[KEL_MAG_W-1:32]);
    nn_hh_r <= 62'(side3_r.un[KEL_MAG_W-1:32]) * 62'(side3_r.un[KEL_MAG_W-1:32]);
    ab_ll_r <= 64'(side3_r.ua[31:0]) * 64'(side3_r.ub[31:0]);
    ab_lh_r <= 64'(side3_r.ua[31:0]) * 64'(side3_r.ub[KEL_MAG_W-1:32]);
    ab_hl_r <= 64'(side3_r.ua[KEL_MAG_W-1:32]) * 64'(side3_r.ub[31:0]);
    ab_hh_r <= 62'(side3_r.ua[KEL_MAG_W-1:32]) * 62'(side3_r.ub[KEL_MAG_W-1:32]);
    side4_r <= side3_r;

    nn_r    <= nn_nxt;
    ab_r    <= ab_nxt;
    side5_r <= side4_r;

    rad_r   <= diff[KEL_RAD_W-1:0];
    side6_r <= side6_nxt;
  end

  assign out_valid     = v_r[KEL_FRONT_STAGES-1];
  assign out_root.rad  = rad_r;
  assign out_root.rem  = '0;
  assign out_root.root = '0;
  assign out_side      = side6_r;

endmodule

// ----- rtl/core/kel_root_stage.sv -----
module kel_root_stage import kel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  kel_root_t in_root,
  input  kel_side_t in_side,
  output logic      out_valid,
  output kel_root_t out_root,
  output kel_side_t out_side
);

  logic      valid_r;
  kel_root_t root_r;
  kel_side_t side_r;

  logic [KEL_REM_W+1:0] rem_sh;
  logic [KEL_REM_W+1:0] trial;
  logic [KEL_REM_W+2:0] diff;
  logic                 ge;
  kel_root_t            root_nxt;

  always_comb begin
    rem_sh = {in_root.rem, in_root.rad[KEL_RAD_W-1 -: 2]};
    trial  = {2'b00, in_root.root, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    ge     = !diff[KEL_REM_W+2];
    root_nxt.rad  = {in_root.rad[KEL_RAD_W-3:0], 2'b00};
    root_nxt.rem  = ge ? diff[KEL_REM_W-1:0] : rem_sh[KEL_REM_W-1:0];
    root_nxt.root = {in_root.root[KEL_ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

// ----- rtl/core/kel_log2.sv -----
module kel_log2 import kel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [63:0]          in_x,
  output logic                 out_valid,
  output logic [KEL_LOG_W-1:0] out_log
);

  logic [KEL_LOG_STAGES-1:0] vld_r;

  logic [63:0]            l1_x_r;
  logic [7:0]             l1_nz_r;
  logic [2:0]             l1_msb_r [8];
  logic [63:0]            l2_x_r;
  logic [KEL_LOG_K_W-1:0] l2_k_r;

  logic [KEL_MANT_W-1:0]     it_m_r [KEL_LOG_ITERS+1];
  logic [KEL_LOG_K_W-1:0]    it_k_r [KEL_LOG_ITERS+1];
  logic [KEL_LOG_FRAC_W-1:0] it_f_r [KEL_LOG_ITERS+1];

  logic [7:0]             nz_nxt;
  logic [2:0]             msb_nxt [8];
  logic [KEL_LOG_K_W-1:0] k_nxt;
  logic [63:0]            shifted;
  logic [61:0]            sq [KEL_LOG_ITERS];
  logic [31:0]            sh [KEL_LOG_ITERS];

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_nxt[g]  = |in_x[8*g +: 8];
      msb_nxt[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (in_x[8*g+b]) begin
          msb_nxt[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    k_nxt = '0;
    for (int g = 0; g < 8; g++) begin
      if (l1_nz_r[g]) begin
        k_nxt = {3'(g), l1_msb_r[g]};
      end
    end
  end

  always_comb begin
    if (l2_k_r >= 6'd30) begin
      shifted = l2_x_r >> (l2_k_r - 6'd30);
    end else begin
      shifted = l2_x_r << (6'd30 - l2_k_r);
    end
  end

  always_comb begin
    for (int j = 0; j < KEL_LOG_ITERS; j++) begin
      sq[j] = 62'(it_m_r[j]) * 62'(it_m_r[j]);
      sh[j] = sq[j][61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[KEL_LOG_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    l1_x_r   <= in_x;
    l1_nz_r  <= nz_nxt;
    l1_msb_r <= msb_nxt;
    l2_x_r   <= l1_x_r;
    l2_k_r   <= k_nxt;
    it_m_r[0] <= shifted[KEL_MANT_W-1:0];
    it_k_r[0] <= l2_k_r;
    it_f_r[0] <= '0;
    for (int j = 0; j < KEL_LOG_ITERS; j++) begin
      it_m_r[j+1] <= sh[j][31] ? sh[j][31:1] : sh[j][30:0];
      it_k_r[j+1] <= it_k_r[j];
      it_f_r[j+1] <= it_f_r[j] | (KEL_LOG_FRAC_W'(sh[j][31]) << (KEL_LOG_ITERS-1-j));
    end
  end

  assign out_valid = vld_r[KEL_LOG_STAGES-1];
  assign out_log   = {it_k_r[KEL_LOG_ITERS], it_f_r[KEL_LOG_ITERS]};

endmodule

// ----- rtl/core/kel_chk.sv -----
`include "klein_edge_length_assert.svh"

module kel_chk import kel_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [31:0] in_head_x,
  input logic [31:0] in_head_y,
  input logic [31:0] in_head_z,
  input logic [31:0] in_tail_x,
  input logic [31:0] in_tail_y,
  input logic [31:0] in_tail_z,
  input logic        cfg_we,
  input logic [1:0]  cfg_wdata,
  input logic        out_strobe,
  input logic [31:0] out_edge_length,
  input logic        out_outside_disk
);

  logic accept;
  logic origin;

  assign accept = start && !busy;
  assign origin = (in_head_x == '0) && (in_head_y == '0) && (in_head_z == '0) &&
                  (in_tail_x == '0) && (in_tail_y == '0) && (in_tail_z == '0);

  `KEL_ASSERT_LAT(a_lat_fwd, accept, out_strobe, "transaction produced no result")
  `KEL_ASSERT_NOW(a_lat_back, out_strobe, $past(accept, KEL_LATENCY), "result without transaction")
  `KEL_ASSERT_NOW(a_outside_zero, out_strobe && out_outside_disk, out_edge_length == '0, "outside with length")
  `KEL_ASSERT_LAT(a_origin, accept && origin, out_strobe && !out_outside_disk && out_edge_length == '0, "origin edge not zero")

endmodule

bind klein_edge_length kel_chk u_kel_chk (.*);
